// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and controller/datapath interface types for the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int USE_BITS     = 8;

  // pointer holds 0..HEAP_BYTES inclusive, index addresses the header memory
  localparam int PTR_W  = $clog2(HEAP_BYTES + 1);
  localparam int IDX_W  = $clog2(HEAP_BYTES);
  localparam int CMP_W  = ((PTR_W > 14) ? PTR_W : 14) + 2;
  localparam int WORD_W = PTR_W + USE_BITS;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 13;
  localparam int PA_W   = 12;
  localparam int ST_W   = 2;
  localparam int RA_W   = 12;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SHARE = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FAIL    = 2'd1;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

  localparam logic [CMP_W-1:0]    HEAP_C = CMP_W'(HEAP_BYTES);
  localparam logic [CMP_W-1:0]    HDR_C  = CMP_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0]    HDR2_C = CMP_W'(2 * HEADER_BYTES);
  localparam logic [USE_BITS-1:0] USE_MAX = '1;

  typedef logic [2:0] asel_t;
  localparam asel_t A_HOLD  = 3'd0;
  localparam asel_t A_ZERO  = 3'd1;
  localparam asel_t A_HDR   = 3'd2;
  localparam asel_t A_RDEND = 3'd3;
  localparam asel_t A_EREG  = 3'd4;

  typedef logic [1:0] rdsel_t;
  localparam rdsel_t RD_ZERO  = 2'd0;
  localparam rdsel_t RD_HDR   = 2'd1;
  localparam rdsel_t RD_RDEND = 2'd2;
  localparam rdsel_t RD_EREG  = 2'd3;

  typedef logic [2:0] wrsel_t;
  localparam wrsel_t WR_NONE  = 3'd0;
  localparam wrsel_t WR_A_E0  = 3'd1;
  localparam wrsel_t WR_A_E1  = 3'd2;
  localparam wrsel_t WR_A_T1  = 3'd3;
  localparam wrsel_t WR_T_E0  = 3'd4;
  localparam wrsel_t WR_A_INC = 3'd5;
  localparam wrsel_t WR_A_DEC = 3'd6;

  typedef struct packed {
    logic            ld_req;
    asel_t           a_sel;
    logic            e_ld;
    rdsel_t          rd_sel;
    wrsel_t          wr_sel;
    logic            set_res;
    logic [ST_W-1:0] res_status;
    logic            res_addr_en;
    logic            ld_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad_size;
    logic            bad_pa;
    logic            rd_bad;
    logic            rd_used;
    logic            rd_end_ge_heap;
    logic            m_ok;
    logic            e_ge_heap;
    logic            fits;
    logic            split;
    logic            use_max;
    logic            use_one;
    logic            out_free;
  } stat_t;

endpackage

// ===== sv/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the allocator: decodes a word, walks and merges the cell
// chain one header per cycle, and issues header writes and the result.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ACHK   = 4'd2;
  localparam logic [3:0] S_MCHK   = 4'd3;
  localparam logic [3:0] S_FIT    = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_UCHK   = 4'd6;
  localparam logic [3:0] S_FREEWR = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [3:0] after_merge;

  assign in_stall    = (state_r != S_IDLE);
  assign after_merge = (stat.op == OP_ALLOC) ? S_FIT : S_FREEWR;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op == OP_ALLOC) begin
          if (stat.bad_size) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_FAIL;
            state_nxt      = S_OUT;
          end else begin
            cmd.a_sel  = A_ZERO;
            cmd.rd_sel = RD_ZERO;
            state_nxt  = S_ACHK;
          end
        end else if (stat.op == OP_FREE || stat.op == OP_SHARE) begin
          if (stat.bad_pa) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_IGNORED;
            state_nxt      = S_OUT;
          end else begin
            cmd.a_sel  = A_HDR;
            cmd.rd_sel = RD_HDR;
            state_nxt  = S_UCHK;
          end
        end else begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_OUT;
        end
      end
      S_ACHK: begin
        if (stat.rd_bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_FAIL;
          state_nxt      = S_OUT;
        end else if (stat.rd_used) begin
          cmd.a_sel = A_RDEND;
          if (stat.rd_end_ge_heap) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_FAIL;
            state_nxt      = S_OUT;
          end else begin
            cmd.rd_sel = RD_RDEND;
          end
        end else begin
          cmd.e_ld = 1'b1;
          if (stat.rd_end_ge_heap) begin
            state_nxt = S_FIT;
          end else begin
            cmd.rd_sel = RD_RDEND;
            state_nxt  = S_MCHK;
          end
        end
      end
      S_MCHK: begin
        if (stat.m_ok) begin
          cmd.e_ld = 1'b1;
          if (stat.rd_end_ge_heap) begin
            state_nxt = after_merge;
          end else begin
            cmd.rd_sel = RD_RDEND;
          end
        end else begin
          state_nxt = after_merge;
        end
      end
      S_FIT: begin
        if (stat.fits) begin
          if (stat.split) begin
            cmd.wr_sel = WR_A_T1;
            state_nxt  = S_SPLIT;
          end else begin
            cmd.wr_sel      = WR_A_E1;
            cmd.set_res     = 1'b1;
            cmd.res_status  = ST_DONE;
            cmd.res_addr_en = 1'b1;
            state_nxt       = S_OUT;
          end
        end else begin
          cmd.wr_sel = WR_A_E0;
          cmd.a_sel  = A_EREG;
          if (stat.e_ge_heap) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_FAIL;
            state_nxt      = S_OUT;
          end else begin
            cmd.rd_sel = RD_EREG;
            state_nxt  = S_ACHK;
          end
        end
      end
      S_SPLIT: begin
        cmd.wr_sel      = WR_T_E0;
        cmd.set_res     = 1'b1;
        cmd.res_status  = ST_DONE;
        cmd.res_addr_en = 1'b1;
        state_nxt       = S_OUT;
      end
      S_UCHK: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_DONE;
        state_nxt      = S_OUT;
        if (stat.op == OP_SHARE) begin
          if (!stat.use_max) cmd.wr_sel = WR_A_INC;
        end else if (stat.rd_used) begin
          cmd.wr_sel = WR_A_DEC;
          if (stat.use_one) begin
            cmd.set_res = 1'b0;
            cmd.e_ld    = 1'b1;
            if (stat.rd_end_ge_heap) begin
              state_nxt = S_FREEWR;
            end else begin
              cmd.rd_sel = RD_RDEND;
              state_nxt  = S_MCHK;
            end
          end
        end
      end
      S_FREEWR: begin
        cmd.wr_sel     = WR_A_E0;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_DONE;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: request registers, cell pointers, header memory with one
// registered read port and one write port, and the result register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [PA_W-1:0]   in_payload_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [RA_W-1:0]   out_result_addr
);

  logic [OP_W-1:0]   op_r;
  logic [SIZE_W-1:0] size_r;
  logic [PA_W-1:0]   pa_r;
  logic [PTR_W-1:0]  a_r, a_nxt;
  logic [PTR_W-1:0]  e_r;

  logic [WORD_W-1:0] hdr_mem_r [HEAP_BYTES];
  logic [WORD_W-1:0] rdata_r;
  logic              ovr_r;
  logic              hdr0_wr_r;

  logic [ST_W-1:0]   res_status_r;
  logic [RA_W-1:0]   res_addr_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [RA_W-1:0]   out_addr_r;

  logic [PTR_W-1:0]    rd_end;
  logic [USE_BITS-1:0] rd_use;
  logic [CMP_W-1:0]    size_c, need_c, pa_c, h_c, a_c, e_c, rd_end_c, span_c, t_c;
  logic [CMP_W-1:0]    raddr_c, waddr_c;
  logic [WORD_W-1:0]   wdata;
  logic                wr_en;

  // offset 0 reads as the whole free heap until first written
  assign rd_end = ovr_r ? PTR_W'(HEAP_BYTES) : rdata_r[WORD_W-1:USE_BITS];
  assign rd_use = ovr_r ? '0 : rdata_r[USE_BITS-1:0];

  assign size_c   = CMP_W'(size_r);
  assign need_c   = size_c + HDR_C;
  assign pa_c     = CMP_W'(pa_r);
  assign h_c      = pa_c - HDR_C;
  assign a_c      = CMP_W'(a_r);
  assign e_c      = CMP_W'(e_r);
  assign rd_end_c = CMP_W'(rd_end);
  assign span_c   = e_c - a_c;
  assign t_c      = a_c + need_c;

  always_comb begin
    stat                = '0;
    stat.op             = op_r;
    stat.bad_size       = (size_r == '0) || (need_c > HEAP_C);
    stat.bad_pa         = (pa_c < HDR_C) || (h_c >= HEAP_C);
    stat.rd_bad         = (rd_end_c <= a_c) || (rd_end_c > HEAP_C);
    stat.rd_used        = (rd_use != '0);
    stat.rd_end_ge_heap = (rd_end_c >= HEAP_C);
    stat.m_ok           = (rd_use == '0) && (rd_end_c > e_c) && (rd_end_c <= HEAP_C);
    stat.e_ge_heap      = (e_c >= HEAP_C);
    stat.fits           = (span_c >= need_c);
    stat.split          = (span_c > size_c + HDR2_C);
    stat.use_max        = (rd_use == USE_MAX);
    stat.use_one        = (rd_use == USE_BITS'(1));
    stat.out_free       = !out_valid_r || !out_stall;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO:  raddr_c = '0;
      RD_HDR:   raddr_c = h_c;
      RD_RDEND: raddr_c = rd_end_c;
      RD_EREG:  raddr_c = e_c;
      default:  raddr_c = '0;
    endcase
  end

  always_comb begin
    case (cmd.a_sel)
      A_ZERO:  a_nxt = '0;
      A_HDR:   a_nxt = h_c[PTR_W-1:0];
      A_RDEND: a_nxt = rd_end;
      A_EREG:  a_nxt = e_r;
      default: a_nxt = a_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    waddr_c = a_c;
    wdata   = {e_r, {USE_BITS{1'b0}}};
    case (cmd.wr_sel)
      WR_A_E0:  wdata = {e_r, {USE_BITS{1'b0}}};
      WR_A_E1:  wdata = {e_r, USE_BITS'(1)};
      WR_A_T1:  wdata = {t_c[PTR_W-1:0], USE_BITS'(1)};
      WR_T_E0: begin
        waddr_c = t_c;
        wdata   = {e_r, {USE_BITS{1'b0}}};
      end
      WR_A_INC: wdata = {rd_end, rd_use + USE_BITS'(1)};
      WR_A_DEC: wdata = {rd_end, rd_use - USE_BITS'(1)};
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) hdr_mem_r[waddr_c[IDX_W-1:0]] <= wdata;
    rdata_r <= hdr_mem_r[raddr_c[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      op_r   <= in_op;
      size_r <= in_req_size;
      pa_r   <= in_payload_addr;
    end
    a_r <= a_nxt;
    if (cmd.e_ld) e_r <= rd_end;
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_addr_r   <= cmd.res_addr_en ? RA_W'(a_c + HDR_C) : '0;
    end
    if (cmd.ld_out) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_wr_r   <= 1'b0;
      ovr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en && waddr_c == '0) hdr0_wr_r <= 1'b1;
      ovr_r <= (raddr_c == '0) && !hdr0_wr_r;
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (waddr_c < HEAP_C))
    else $error("header write outside heap");

  a_split_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel == WR_A_T1) |-> (t_c > a_c && t_c < e_c))
    else $error("split point outside cell");

  a_split_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_sel == WR_A_T1) |=> (cmd.wr_sel == WR_T_E0))
    else $error("split tail header not written");
`endif

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with coalescing and per-cell use counts.
// ----------------------------------------------------------------------------
// One request word at a time. Every step reads one cell header through the
// header memory's single registered read port, so the time a request takes
// grows with the length of the chain walk. Allocate visits cells from offset
// 0, reads the neighbour headers of each free cell while merging, and writes
// one more header when a free tail is split off. Share and free read the
// cell's own header; free also merges the free neighbours when the count
// drops to zero. A rejected or unknown request is answered without a header
// read. The next word is taken while a result still waits on a stalled
// output. No clearing pass is needed after reset: only the header at offset
// 0 has a reset value, held by a single flag.
module first_fit_heap_allocator_unit import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [PA_W-1:0]   in_payload_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [RA_W-1:0]   out_result_addr
);

  cmd_t  cmd;
  stat_t stat;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_req_size     (in_req_size),
    .in_payload_addr (in_payload_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_addr (out_result_addr)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator: a cycle-free heap
// model predicts every result word, directed tests cover the size limits,
// null addresses, splitting, merging and use-count saturation, and random
// traffic mixes allocate, free and share under sender gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ffha_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [RA_W-1:0] addr;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = OP_ALLOC;
  logic [SIZE_W-1:0] in_req_size = '0;
  logic [PA_W-1:0]   in_payload_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic [RA_W-1:0]   out_result_addr;

  // heap model
  int unsigned       hdr_end [HEAP_BYTES];
  logic [USE_BITS-1:0] hdr_use [HEAP_BYTES];
  bit                hdr_seen [HEAP_BYTES];

  reply_t            pending_results [$];
  int unsigned       granted [$];
  reply_t            check_word;
  int                errors = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                hold_request = 0;
  int                hold_left = 0;

  first_fit_heap_allocator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_req_size     (in_req_size),
    .in_payload_addr (in_payload_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_addr (out_result_addr)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected word: status %0d addr %0d", $time, out_status,
                 out_result_addr);
      end else begin
        check_word = pending_results.pop_front();
        if (out_status !== check_word.status) begin
          errors++;
          $display("%0t status expected %0d, got %0d", $time, check_word.status,
                   out_status);
        end
        if (out_result_addr !== check_word.addr) begin
          errors++;
          $display("%0t result_addr expected %0d, got %0d", $time, check_word.addr,
                   out_result_addr);
        end
      end
    end
  end

  function automatic int unsigned coalesce_from(int unsigned e);
    int unsigned nx;
    while (e < HEAP_BYTES && hdr_use[e] == 0) begin
      nx = hdr_end[e];
      if (nx <= e || nx > HEAP_BYTES) break;
      e = nx;
    end
    return e;
  endfunction

  function automatic reply_t predict_alloc(int unsigned size);
    int unsigned need, a, e, t;
    reply_t r;
    r.status = ST_FAIL;
    r.addr = '0;
    need = size + HEADER_BYTES;
    a = 0;
    if (size == 0 || need > HEAP_BYTES) return r;
    while (a < HEAP_BYTES) begin
      e = hdr_end[a];
      if (e <= a || e > HEAP_BYTES) return r;
      if (hdr_use[a] == 0) begin
        e = coalesce_from(e);
        hdr_end[a] = e;
        if (e - a >= need) begin
          hdr_use[a] = 1;
          if (e - a > size + 2 * HEADER_BYTES) begin
            t = a + need;
            hdr_end[a] = t;
            hdr_end[t] = e;
            hdr_use[t] = 0;
            hdr_seen[t] = 1'b1;
          end
          r.status = ST_DONE;
          r.addr = RA_W'(a + HEADER_BYTES);
          return r;
        end
      end
      a = e;
    end
    return r;
  endfunction

  function automatic reply_t predict_word(logic [OP_W-1:0] op, int unsigned size,
                                          int unsigned pa);
    int unsigned h;
    reply_t r;
    r.status = ST_DONE;
    r.addr = '0;
    if (op == OP_ALLOC) begin
      r = predict_alloc(size);
    end else if (op == OP_FREE || op == OP_SHARE) begin
      if (pa < HEADER_BYTES || pa - HEADER_BYTES >= HEAP_BYTES) begin
        r.status = ST_IGNORED;
      end else begin
        h = pa - HEADER_BYTES;
        if (op == OP_SHARE) begin
          if (hdr_use[h] != USE_MAX) hdr_use[h]++;
        end else if (hdr_use[h] != 0) begin
          hdr_use[h]--;
          if (hdr_use[h] == 0) hdr_end[h] = coalesce_from(hdr_end[h]);
        end
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input int unsigned size,
                           input int unsigned pa, output reply_t rep);
    int gap;
    gap = 0;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_req_size <= SIZE_W'(size);
    in_payload_addr <= PA_W'(pa);
    do @(posedge clk); while (in_stall);
    rep = predict_word(op, size, pa);
    pending_results.push_back(rep);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly live-block traffic; the rest hits stale headers, null and op 3
  task automatic random_word();
    int r, s, k, tries;
    int unsigned size, pa, h;
    logic [OP_W-1:0] op;
    reply_t rep;
    r = $urandom_range(99);
    k = -1;
    size = $urandom_range(8191);
    pa = $urandom_range(4095);
    op = OP_NONE;
    if (r < 40 || (granted.size() == 0 && r < 88)) begin
      op = OP_ALLOC;
      s = $urandom_range(99);
      if (s < 80) size = $urandom_range(128, 1);
      else if (s < 95) size = $urandom_range(1024, 129);
      else if (s < 99) size = $urandom_range(4096, 1025);
      else size = $urandom_range(8191);
    end else if (r < 88) begin
      op = (r < 78) ? OP_FREE : OP_SHARE;
      k = $urandom_range(granted.size() - 1);
      pa = granted[k];
    end else if (r < 98) begin
      op = $urandom_range(1) ? OP_FREE : OP_SHARE;
      if (r < 94) begin
        h = 0;
        for (tries = 0; tries < 32; tries++) begin
          h = $urandom_range(HEAP_BYTES - HEADER_BYTES - 1);
          if (hdr_seen[h]) break;
        end
        if (!hdr_seen[h]) h = 0;
        pa = h + HEADER_BYTES;
      end else begin
        pa = $urandom_range(HEADER_BYTES - 1);
      end
    end
    send_word(op, size, pa, rep);
    if (op == OP_ALLOC && rep.status == ST_DONE) granted.push_back(rep.addr);
    if (k >= 0 && hdr_use[pa - HEADER_BYTES] == 0) granted.delete(k);
  endtask

  task automatic test_size_limits();
    reply_t rep;
    send_word(OP_ALLOC, 0, 0, rep);
    send_word(OP_ALLOC, HEAP_BYTES, 0, rep);
    send_word(OP_ALLOC, 8191, 4095, rep);
    send_word(OP_ALLOC, HEAP_BYTES - HEADER_BYTES, 0, rep);
    send_word(OP_ALLOC, 1, 0, rep);
    drain();
  endtask

  task automatic test_null_and_unknown();
    reply_t rep;
    send_word(OP_SHARE, 0, 16, rep);
    send_word(OP_FREE, 0, 16, rep);
    send_word(OP_FREE, 0, 16, rep);
    send_word(OP_FREE, 0, 16, rep);
    send_word(OP_FREE, 0, 0, rep);
    send_word(OP_SHARE, 0, 15, rep);
    send_word(OP_NONE, 8191, 4095, rep);
    drain();
  endtask

  // split tails, exact fits, the one-header boundary and a block at the top
  task automatic test_split_and_merge();
    reply_t rep;
    send_word(OP_ALLOC, 1, 0, rep);
    send_word(OP_ALLOC, 4063, 0, rep);
    send_word(OP_ALLOC, 1, 0, rep);
    send_word(OP_FREE, 0, 16, rep);
    send_word(OP_FREE, 0, 33, rep);
    send_word(OP_ALLOC, 4064, 0, rep);
    send_word(OP_FREE, 0, 16, rep);
    send_word(OP_ALLOC, 4063, 0, rep);
    send_word(OP_ALLOC, 1, 0, rep);
    send_word(OP_SHARE, 0, 4095, rep);
    send_word(OP_FREE, 0, 4095, rep);
    send_word(OP_FREE, 0, 4095, rep);
    send_word(OP_FREE, 0, 16, rep);
    drain();
  endtask

  task automatic test_share_saturation();
    reply_t rep;
    stall_pct = 58;
    send_word(OP_ALLOC, 8, 0, rep);
    repeat (258) send_word(OP_SHARE, 0, HEADER_BYTES, rep);
    repeat (258) send_word(OP_FREE, 0, HEADER_BYTES, rep);
    drain();
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    repeat (40) random_word();
    drain();
  endtask

  task automatic test_random_traffic();
    int sender_idle [4] = '{0, 58, 0, 6};
    int receiver_stall [4] = '{0, 0, 58, 6};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_idle[p];
      stall_pct = receiver_stall[p];
      repeat (225) random_word();
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < HEAP_BYTES; i++) begin
      hdr_end[i] = 0;
      hdr_use[i] = '0;
      hdr_seen[i] = 1'b0;
    end
    hdr_end[0] = HEAP_BYTES;
    hdr_seen[0] = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_size_limits();
    test_null_and_unknown();
    test_split_and_merge();
    test_share_saturation();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ffha_pkg.sv
sv/ffha_ctrl.sv
sv/ffha_dp.sv
sv/first_fit_heap_allocator_unit.sv
tb/sv/tb_top.sv
